FILE: rtl/core/assert_macros.svh
// Assertion helpers for the delta token parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DTSP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define DTSP_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define DTSP_ASSERT(lbl, clk, rst_n, prop)
`define DTSP_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/core/dtsp_pkg.sv
`timescale 1ns / 1ps

package dtsp_pkg;

	// parser phase
	typedef enum logic [1:0] {
		PH_TOKEN    = 2'd0,
		PH_LITERAL  = 2'd1,
		PH_TRAILER  = 2'd2,
		PH_FINISHED = 2'd3
	} phase_t;

	// result word kind
	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_BLOCK   = 2'd1,
		KIND_DIGEST  = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	localparam int unsigned TOKEN_BYTES = 4;
	localparam logic [1:0] TOKEN_LAST_BYTE = 2'(TOKEN_BYTES - 1);

endpackage

FILE: rtl/core/delta_token_stream_parser.sv
// Delta token stream parser: one byte word in, at most one result word out.
// A result is registered and presented in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the result register lets the next byte in
// while the held result is taken, and stalls input only when it is full.
// Reset (arst_n low, asynchronous): token phase, all counters cleared, no result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module delta_token_stream_parser
	import dtsp_pkg::*;
#(
	parameter int unsigned DIGEST_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_ready,
	input  logic [7:0]  in_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [30:0] block_index,
	output logic [3:0]  digest_position,
	output logic        stream_done
);

	localparam int unsigned TW = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1;
	localparam logic [TW-1:0] LAST_POS = TW'(DIGEST_BYTES - 1);

	phase_t        phase_q, phase_d;
	logic [23:0]   acc_q, acc_d;
	logic [1:0]    tcnt_q, tcnt_d;
	logic [30:0]   lit_q, lit_d;
	logic [TW-1:0] trail_q, trail_d;

	logic          accept;
	logic [31:0]   token;
	logic          has_res;
	kind_t         kind_d;
	logic [7:0]    data_d;
	logic [30:0]   index_d;
	logic [3:0]    pos_d;
	logic          done_d;
	logic [TW+3:0] pos_ext;

	logic          res_valid_q;
	kind_t         kind_q;
	logic [7:0]    data_q;
	logic [30:0]   index_q;
	logic [3:0]    pos_q;
	logic          done_q;

	// take a byte whenever the result register is free or being drained
	assign src_ready = !res_valid_q || res_ready;
	assign accept    = src_valid && src_ready;
	assign token     = {acc_q, in_byte};
	assign pos_ext   = {4'b0000, trail_q};

	// next parser state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		tcnt_d  = tcnt_q;
		lit_d   = lit_q;
		trail_d = trail_q;
		case (phase_q)
			PH_TOKEN: begin
				acc_d = token[23:0];
				if (tcnt_q != TOKEN_LAST_BYTE) begin
					tcnt_d = tcnt_q + 2'd1;
				end else begin
					tcnt_d = 2'd0;
					acc_d  = 24'd0;
					if (token == 32'd0) begin
						phase_d = PH_TRAILER;
						trail_d = '0;
					end else if (!token[31]) begin
						phase_d = PH_LITERAL;
						lit_d   = token[30:0];
					end
				end
			end
			PH_LITERAL: begin
				if (lit_q <= 31'd1) begin
					lit_d   = 31'd0;
					phase_d = PH_TOKEN;
				end else begin
					lit_d = lit_q - 31'd1;
				end
			end
			PH_TRAILER: begin
				if (trail_q == LAST_POS) begin
					phase_d = PH_FINISHED;
					trail_d = '0;
				end else begin
					trail_d = trail_q + TW'(1);
				end
			end
			default: begin
				phase_d = PH_FINISHED;
			end
		endcase
	end

	// result word for the current byte
	always_comb begin
		has_res = 1'b1;
		kind_d  = KIND_ERROR;
		data_d  = in_byte;
		index_d = 31'd0;
		pos_d   = 4'd0;
		done_d  = 1'b0;
		case (phase_q)
			PH_TOKEN: begin
				kind_d  = KIND_BLOCK;
				data_d  = 8'd0;
				index_d = ~token[30:0];
				has_res = (tcnt_q == TOKEN_LAST_BYTE) && token[31];
			end
			PH_LITERAL: begin
				kind_d = KIND_LITERAL;
			end
			PH_TRAILER: begin
				kind_d = KIND_DIGEST;
				pos_d  = pos_ext[3:0];
				done_d = (trail_q == LAST_POS);
			end
			default: begin
				kind_d = KIND_ERROR;
			end
		endcase
	end

	// advance parser state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
			acc_q   <= 24'd0;
			tcnt_q  <= 2'd0;
			lit_q   <= 31'd0;
			trail_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			tcnt_q  <= tcnt_d;
			lit_q   <= lit_d;
			trail_q <= trail_d;
		end
	end

	// hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= has_res;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_res) begin
			kind_q  <= kind_d;
			data_q  <= data_d;
			index_q <= index_d;
			pos_q   <= pos_d;
			done_q  <= done_d;
		end
	end

	assign res_valid       = res_valid_q;
	assign kind            = kind_q;
	assign data_byte       = data_q;
	assign block_index     = index_q;
	assign digest_position = pos_q;
	assign stream_done     = done_q;

	// checks
	`DTSP_ASSERT(a_err_after_end, clk, arst_n, accept && phase_q == PH_FINISHED |=> res_valid_q && kind_q == KIND_ERROR)
	`DTSP_ASSERT(a_done_is_digest, clk, arst_n, res_valid_q && done_q |-> kind_q == KIND_DIGEST)
	`DTSP_ASSERT(a_lit_nonzero, clk, arst_n, phase_q == PH_LITERAL |-> lit_q != 31'd0)
	`DTSP_NEVER(a_tcnt_token_only, clk, arst_n, tcnt_q != 2'd0 && phase_q != PH_TOKEN)
	`DTSP_ASSERT(a_block_clean, clk, arst_n, res_valid_q && kind_q == KIND_BLOCK |-> data_q == 8'd0 && pos_q == 4'd0)

endmodule
